/* sv/sic_pkg.sv */
// Package for the scheduled irrigation controller.
// Holds the item structs, command and register codes and schedule constants.
// No dependencies; used by scheduled_irrigation_controller_top and its checker.
`default_nettype none

package sic_pkg;

  // Schedule geometry
  localparam int SLOTS  = 24;
  localparam int DAYS   = 7;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 3;
  localparam int SAMPLE_W = 10;
  localparam int TEMP_W   = 8;
  localparam int MASK_W   = 7;
  localparam int MIN_W    = 7;
  localparam int AREA_W   = 4;
  localparam int PUMP_W   = 8;
  localparam int THR_W    = 7;
  localparam int TPM_W    = 6;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Reset values
  localparam logic [THR_W-1:0]  MOIST_THR_RESET = THR_W'(94);
  localparam logic [TEMP_W-1:0] TEMP_LIM_RESET  = TEMP_W'(34);
  localparam logic [TPM_W-1:0]  TPM_RESET       = TPM_W'(6);
  localparam logic [MIN_W-1:0]  SLOT_MIN_RESET  = MIN_W'(15);

  // Soil scaling: percent = 100 - floor(sample * 100 / 1023)
  localparam int PERCENT_FULL = 100;
  localparam int SAMPLE_FULL  = 1023;

  typedef enum logic [1:0] {
    CMD_TICK          = 2'd0,
    CMD_WRITE_DAYS    = 2'd1,
    CMD_WRITE_MINUTES = 2'd2,
    CMD_QUICK         = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MOIST_THR = 2'd0,
    REG_TEMP_LIM  = 2'd1,
    REG_TPM       = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t                command;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    weekday;
    logic [SAMPLE_W-1:0] soil_sample;
    logic [TEMP_W-1:0]   temperature;
    logic                temperature_ok;
    logic                slot_enable;
    logic [MASK_W-1:0]   day_mask;
    logic [MIN_W-1:0]    minutes;
    logic [AREA_W-1:0]   area;
  } in_item_t;

  typedef struct packed {
    logic [PUMP_W-1:0] pump_mask;
    logic              watering;
    logic              write_rejected;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/scheduled_irrigation_controller_top.sv */
// Top level of the scheduled irrigation controller: schedule, run control, APB registers.
// Depends on sic_pkg.
//
//  channel  | ports                                        | accepted when
//  ---------+----------------------------------------------+-----------------------------
//  input    | start, busy, in_item                         | start && !busy at clk rise
//  result   | out_valid, out_item                          | edge ending out_valid cycle
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | psel&penable&pwrite&pready
//
// Each item is registered, evaluated in the next cycle and its result is shown the
// cycle after; one item per cycle, busy never rises.
// The path from input register to result register (soil scaling and the slot read)
// sets the cycle time. Synchronous active-low reset restores the schedule and
// registers; no clearing pass. The receiver cannot stall the result strobe.
`default_nettype none

module scheduled_irrigation_controller_top (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              start,
  output logic                             busy,
  input  wire sic_pkg::in_item_t           in_item,
  // result channel
  output logic                             out_valid,
  output sic_pkg::out_item_t               out_item,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [sic_pkg::PADDR_W-1:0]       paddr,
  input  wire [sic_pkg::PDATA_W-1:0]       pwdata,
  output logic [sic_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int SW = sic_pkg::SLOT_W;

  // Input register
  logic               in_valid_r;
  sic_pkg::in_item_t  in_r;

  // Configuration registers
  logic [sic_pkg::THR_W-1:0]  moist_thr_r;
  logic [sic_pkg::TEMP_W-1:0] temp_lim_r;
  logic [sic_pkg::TPM_W-1:0]  tpm_r;

  // Schedule
  logic                        slot_en_r   [sic_pkg::SLOTS];
  logic [sic_pkg::MASK_W-1:0]  slot_days_r [sic_pkg::SLOTS];
  logic [sic_pkg::MIN_W-1:0]   slot_min_r  [sic_pkg::SLOTS];
  logic [sic_pkg::SLOTS-1:0]   slot_done_r, slot_done_nxt;

  // Run state
  logic                         running_r, running_nxt;
  logic [sic_pkg::PUMP_W-1:0]   pumps_r, pumps_nxt;
  logic [sic_pkg::TPM_W-1:0]    tick_cnt_r, tick_cnt_nxt;
  logic [sic_pkg::MIN_W-1:0]    min_elapsed_r, min_elapsed_nxt;
  logic [sic_pkg::MIN_W-1:0]    min_target_r, min_target_nxt;
  logic [sic_pkg::HOUR_W-1:0]   cur_hour_r, cur_hour_nxt;
  logic [sic_pkg::HOUR_W-1:0]   fin_hour_r, fin_hour_nxt;
  logic                         hour_seen_r, hour_seen_nxt;
  logic [sic_pkg::TEMP_W-1:0]   last_temp_r, last_temp_nxt;

  // Result register
  logic                 out_valid_r;
  sic_pkg::out_item_t   out_r, out_nxt;

  // Slot write strobes
  logic slot_days_we, slot_min_we;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // ---------------------------------------------------------------------------
  // Slot addressing and due check
  logic            hr_ok, cur_ok, fin_ok;
  logic [SW-1:0]   hr_idx, cur_idx, fin_idx;
  logic            day_ok;
  logic [2:0]      day_sel;
  logic            due;

  assign hr_ok   = {1'b0, in_r.hour} < (sic_pkg::HOUR_W+1)'(sic_pkg::SLOTS);
  assign cur_ok  = {1'b0, cur_hour_r} < (sic_pkg::HOUR_W+1)'(sic_pkg::SLOTS);
  assign fin_ok  = {1'b0, fin_hour_r} < (sic_pkg::HOUR_W+1)'(sic_pkg::SLOTS);
  assign hr_idx  = in_r.hour[SW-1:0];
  assign cur_idx = cur_hour_r[SW-1:0];
  assign fin_idx = fin_hour_r[SW-1:0];
  assign day_ok  = (in_r.weekday != '0) &&
                   (in_r.weekday <= sic_pkg::DAY_W'(sic_pkg::DAYS));
  assign day_sel = 3'(in_r.weekday - 3'd1);

  always_comb begin
    due = 1'b0;
    if (hr_ok && day_ok) begin
      due = slot_en_r[hr_idx] && !slot_done_r[hr_idx] && slot_days_r[hr_idx][day_sel];
    end
  end

  // ---------------------------------------------------------------------------
  // Soil percent: divide by 1023 as shift by 10 plus one correction step
  logic [16:0] soil_prod;
  logic [6:0]  soil_q0;
  logic [10:0] soil_rem;
  logic [6:0]  soil_q;
  logic [6:0]  soil_pct;
  logic        soil_dry;
  logic [sic_pkg::TEMP_W-1:0] temp_eff;
  logic        temp_cool;

  assign soil_prod = {1'b0, in_r.soil_sample, 6'b0} + {2'b0, in_r.soil_sample, 5'b0}
                   + {5'b0, in_r.soil_sample, 2'b0};
  assign soil_q0   = soil_prod[16:10];
  assign soil_rem  = {1'b0, soil_prod[9:0]} + {4'b0, soil_q0};
  assign soil_q    = soil_q0 + 7'((soil_rem >= 11'(sic_pkg::SAMPLE_FULL)) ? 1 : 0);
  assign soil_pct  = 7'(sic_pkg::PERCENT_FULL) - soil_q;
  assign soil_dry  = soil_pct < moist_thr_r;
  assign temp_eff  = in_r.temperature_ok ? in_r.temperature : last_temp_r;
  assign temp_cool = temp_eff < temp_lim_r;

  // ---------------------------------------------------------------------------
  // Minute counting while watering
  logic [sic_pkg::TPM_W:0]     cnt_inc;
  logic                        minute_up;
  logic [sic_pkg::MIN_W-1:0]   el_inc;
  logic                        run_end;
  logic [2:0]                  pump_sel;
  logic                        area_ok;

  assign cnt_inc   = {1'b0, tick_cnt_r} + (sic_pkg::TPM_W+1)'(1);
  assign minute_up = cnt_inc >= {1'b0, tpm_r};
  assign el_inc    = min_elapsed_r + sic_pkg::MIN_W'(1);
  assign run_end   = el_inc >= min_target_r;
  assign pump_sel  = 3'(in_r.area - 4'd1);
  assign area_ok   = (in_r.area != '0) && (in_r.area <= 4'd8);

  // ---------------------------------------------------------------------------
  // Next-state logic for one item
  always_comb begin
    slot_done_nxt   = slot_done_r;
    running_nxt     = running_r;
    pumps_nxt       = pumps_r;
    tick_cnt_nxt    = tick_cnt_r;
    min_elapsed_nxt = min_elapsed_r;
    min_target_nxt  = min_target_r;
    cur_hour_nxt    = cur_hour_r;
    fin_hour_nxt    = fin_hour_r;
    hour_seen_nxt   = hour_seen_r;
    last_temp_nxt   = last_temp_r;
    slot_days_we    = 1'b0;
    slot_min_we     = 1'b0;
    out_nxt.write_rejected = 1'b0;

    case (in_r.command)
      sic_pkg::CMD_TICK: begin
        if (running_r) begin
          tick_cnt_nxt = cnt_inc[sic_pkg::TPM_W-1:0];
          if (minute_up) begin
            tick_cnt_nxt    = '0;
            min_elapsed_nxt = el_inc;
            if (run_end) begin
              pumps_nxt       = '0;
              min_elapsed_nxt = '0;
              running_nxt     = 1'b0;
              if (cur_ok) slot_done_nxt[cur_idx] = 1'b1;
              fin_hour_nxt    = cur_hour_r;
              hour_seen_nxt   = 1'b0;
            end
          end
        end else begin
          cur_hour_nxt = in_r.hour;
          // hour moved on: re-arm the slot that last finished
          if ((in_r.hour != fin_hour_r) && !hour_seen_r) begin
            if (fin_ok) slot_done_nxt[fin_idx] = 1'b0;
            hour_seen_nxt = 1'b1;
          end
          if (due) begin
            min_target_nxt = slot_min_r[hr_idx];
            last_temp_nxt  = temp_eff;
            if (soil_dry && temp_cool) begin
              pumps_nxt   = pumps_r | sic_pkg::PUMP_W'(1);
              running_nxt = 1'b1;
              slot_done_nxt[hr_idx] = 1'b0;
            end
          end
        end
      end
      sic_pkg::CMD_WRITE_DAYS: begin
        if (hr_ok) slot_days_we = 1'b1;
        else out_nxt.write_rejected = 1'b1;
      end
      sic_pkg::CMD_WRITE_MINUTES: begin
        if (hr_ok) begin
          slot_min_we    = 1'b1;
          min_target_nxt = in_r.minutes;
        end else begin
          out_nxt.write_rejected = 1'b1;
        end
      end
      default: begin
        // quick water, ignored while a run is going
        if (!running_r) begin
          if (area_ok) pumps_nxt = pumps_r | (sic_pkg::PUMP_W'(1) << pump_sel);
          running_nxt    = 1'b1;
          if (cur_ok) slot_done_nxt[cur_idx] = 1'b0;
          min_target_nxt = in_r.minutes;
        end
      end
    endcase

    out_nxt.pump_mask = pumps_nxt;
    out_nxt.watering  = running_nxt;
  end

  // ---------------------------------------------------------------------------
  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    if (start && !busy) in_r <= in_item;
  end

  // ---------------------------------------------------------------------------
  // Schedule and run state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sic_pkg::SLOTS; i++) begin
        slot_en_r[i]   <= 1'b0;
        slot_days_r[i] <= '0;
        slot_min_r[i]  <= sic_pkg::SLOT_MIN_RESET;
      end
      slot_done_r   <= '0;
      running_r     <= 1'b0;
      pumps_r       <= '0;
      tick_cnt_r    <= '0;
      min_elapsed_r <= '0;
      min_target_r  <= '0;
      cur_hour_r    <= '0;
      fin_hour_r    <= '0;
      hour_seen_r   <= 1'b0;
      last_temp_r   <= '0;
    end else if (in_valid_r) begin
      if (slot_days_we) begin
        slot_en_r[hr_idx] <= in_r.slot_enable;
        if (in_r.slot_enable) slot_days_r[hr_idx] <= in_r.day_mask;
      end
      if (slot_min_we) slot_min_r[hr_idx] <= in_r.minutes;
      slot_done_r   <= slot_done_nxt;
      running_r     <= running_nxt;
      pumps_r       <= pumps_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      min_elapsed_r <= min_elapsed_nxt;
      min_target_r  <= min_target_nxt;
      cur_hour_r    <= cur_hour_nxt;
      fin_hour_r    <= fin_hour_nxt;
      hour_seen_r   <= hour_seen_nxt;
      last_temp_r   <= last_temp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) out_r <= out_nxt;
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic               cfg_we;
  sic_pkg::reg_idx_t  cfg_idx;

  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = sic_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moist_thr_r <= sic_pkg::MOIST_THR_RESET;
      temp_lim_r  <= sic_pkg::TEMP_LIM_RESET;
      tpm_r       <= sic_pkg::TPM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sic_pkg::REG_MOIST_THR: moist_thr_r <= pwdata[sic_pkg::THR_W-1:0];
        sic_pkg::REG_TEMP_LIM:  temp_lim_r  <= pwdata[sic_pkg::TEMP_W-1:0];
        sic_pkg::REG_TPM:       tpm_r       <= pwdata[sic_pkg::TPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      sic_pkg::REG_MOIST_THR: prdata = sic_pkg::PDATA_W'(moist_thr_r);
      sic_pkg::REG_TEMP_LIM:  prdata = sic_pkg::PDATA_W'(temp_lim_r);
      sic_pkg::REG_TPM:       prdata = sic_pkg::PDATA_W'(tpm_r);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/sic_checker.sv */
// Port-level checker for the scheduled irrigation controller, with its bind.
// Depends on sic_pkg and scheduled_irrigation_controller_top.
`default_nettype none

module sic_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire sic_pkg::in_item_t   in_item,
  input wire                 out_valid,
  input wire sic_pkg::out_item_t  out_item
);

  // every accepted item yields exactly one result, through the input and result registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2)) |-> (out_valid == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted items");

  // a pump only runs during a watering run
  a_pump_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.pump_mask != '0)) |-> out_item.watering)
    else $error("pump on outside a watering run");

  // quick water always leaves a run in progress
  a_quick_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 2) && ($past(in_item.command, 2) == sic_pkg::CMD_QUICK))
    |-> out_item.watering)
    else $error("quick water did not leave a run in progress");

  // a rejected write came from a slot write to an hour past the schedule
  a_reject_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.write_rejected) |->
      ((($past(in_item.command, 2) == sic_pkg::CMD_WRITE_DAYS) ||
        ($past(in_item.command, 2) == sic_pkg::CMD_WRITE_MINUTES)) &&
       ({1'b0, $past(in_item.hour, 2)} >= (sic_pkg::HOUR_W+1)'(sic_pkg::SLOTS))))
    else $error("write rejected without cause");

endmodule

bind scheduled_irrigation_controller_top sic_checker u_sic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

/* tb/tb_scheduled_irrigation_controller_top.sv */
// Self-checking testbench for scheduled_irrigation_controller_top: directed and random commands
// go through the start/busy port and results are checked against a cycle-free schedule predictor.
// Depends on sic_pkg and the RTL top level only.
`default_nettype none

module tb_scheduled_irrigation_controller_top;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 120;

  // Schedule predictor with its own copy of registers and slot state
  class irrigation_scoreboard;
    logic [sic_pkg::THR_W-1:0]  moist_thr;
    logic [sic_pkg::TEMP_W-1:0] temp_lim;
    logic [sic_pkg::TPM_W-1:0]  tpm;
    bit                         slot_en   [sic_pkg::SLOTS];
    logic [sic_pkg::MASK_W-1:0] slot_days [sic_pkg::SLOTS];
    bit                         slot_done [sic_pkg::SLOTS];
    logic [sic_pkg::MIN_W-1:0]  slot_min  [sic_pkg::SLOTS];
    bit                         running;
    logic [sic_pkg::PUMP_W-1:0] pumps;
    int                         tick_count;
    logic [sic_pkg::MIN_W-1:0]  min_elapsed;
    logic [sic_pkg::MIN_W-1:0]  min_target;
    logic [sic_pkg::HOUR_W-1:0] cur_hour;
    logic [sic_pkg::HOUR_W-1:0] fin_hour;
    bit                         hour_moved;
    logic [sic_pkg::TEMP_W-1:0] last_temp;
    sic_pkg::out_item_t         due_status[$];
    int                         mismatches;

    function new();
      moist_thr  = sic_pkg::MOIST_THR_RESET;
      temp_lim   = sic_pkg::TEMP_LIM_RESET;
      tpm        = sic_pkg::TPM_RESET;
      for (int s = 0; s < sic_pkg::SLOTS; s++) begin
        slot_en[s]   = 1'b0;
        slot_days[s] = '0;
        slot_done[s] = 1'b0;
        slot_min[s]  = sic_pkg::SLOT_MIN_RESET;
      end
      running     = 1'b0;
      pumps       = '0;
      tick_count  = 0;
      min_elapsed = '0;
      min_target  = '0;
      cur_hour    = '0;
      fin_hour    = '0;
      hour_moved  = 1'b0;
      last_temp   = '0;
      mismatches  = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void set_reg(sic_pkg::reg_idx_t idx, logic [sic_pkg::PDATA_W-1:0] v);
      case (idx)
        sic_pkg::REG_MOIST_THR: moist_thr = v[sic_pkg::THR_W-1:0];
        sic_pkg::REG_TEMP_LIM:  temp_lim  = v[sic_pkg::TEMP_W-1:0];
        sic_pkg::REG_TPM:       tpm       = v[sic_pkg::TPM_W-1:0];
        default: ;
      endcase
    endfunction

    // done marks outside the schedule are neither stored nor read
    function void mark_done(logic [sic_pkg::HOUR_W-1:0] slot, bit v);
      if (slot < sic_pkg::SLOTS) slot_done[slot] = v;
    endfunction

    function bit slot_is_due(logic [sic_pkg::HOUR_W-1:0] slot,
                             logic [sic_pkg::DAY_W-1:0] day);
      if (slot >= sic_pkg::SLOTS || day < 1 || day > sic_pkg::DAYS) return 1'b0;
      if (!slot_en[slot] || slot_done[slot]) return 1'b0;
      return slot_days[slot][day-1];
    endfunction

    // Apply one accepted item and queue the status it must produce
    function void note_command(sic_pkg::in_item_t it);
      sic_pkg::out_item_t status;
      int                 pct;
      bit                 rejected;
      rejected = 1'b0;
      case (it.command)
        sic_pkg::CMD_TICK: begin
          if (running) begin
            // minute counting while a run is in progress
            tick_count++;
            if (tick_count >= int'(tpm)) begin
              tick_count  = 0;
              min_elapsed = min_elapsed + 1'b1;
              if (min_elapsed >= min_target) begin
                pumps       = '0;
                min_elapsed = '0;
                running     = 1'b0;
                mark_done(cur_hour, 1'b1);
                fin_hour    = cur_hour;
                hour_moved  = 1'b0;
              end
            end
          end else begin
            cur_hour = it.hour;
            if (it.hour != fin_hour && !hour_moved) begin
              mark_done(fin_hour, 1'b0);
              hour_moved = 1'b1;
            end
            if (slot_is_due(it.hour, it.weekday)) begin
              pct        = sic_pkg::PERCENT_FULL
                         - (int'(it.soil_sample) * sic_pkg::PERCENT_FULL)
                           / sic_pkg::SAMPLE_FULL;
              min_target = slot_min[it.hour];
              if (it.temperature_ok) last_temp = it.temperature;
              if (pct < int'(moist_thr) && last_temp < temp_lim) begin
                pumps[0] = 1'b1;
                running  = 1'b1;
                mark_done(cur_hour, 1'b0);
              end
            end
          end
        end
        sic_pkg::CMD_WRITE_DAYS: begin
          if (it.hour >= sic_pkg::SLOTS) begin
            rejected = 1'b1;
          end else begin
            slot_en[it.hour] = it.slot_enable;
            if (it.slot_enable) slot_days[it.hour] = it.day_mask;
          end
        end
        sic_pkg::CMD_WRITE_MINUTES: begin
          if (it.hour >= sic_pkg::SLOTS) begin
            rejected = 1'b1;
          end else begin
            slot_min[it.hour] = it.minutes;
            min_target        = it.minutes;
          end
        end
        default: begin
          // quick water is ignored while a run is in progress
          if (!running) begin
            if (it.area >= 1 && it.area <= 8)
              pumps = pumps | (sic_pkg::PUMP_W'(1) << (it.area - 1));
            running    = 1'b1;
            mark_done(cur_hour, 1'b0);
            min_target = it.minutes;
          end
        end
      endcase
      status.pump_mask      = pumps;
      status.watering       = running;
      status.write_rejected = rejected;
      due_status.push_back(status);
    endfunction

    function void check_result(sic_pkg::out_item_t got);
      sic_pkg::out_item_t exp;
      if (due_status.size() == 0) begin
        flag($sformatf("unexpected result: pumps=%h watering=%b rejected=%b",
                       got.pump_mask, got.watering, got.write_rejected));
        return;
      end
      exp = due_status.pop_front();
      if (got !== exp)
        flag($sformatf("result mismatch: exp pumps=%h wat=%b rej=%b, got pumps=%h wat=%b rej=%b",
                       exp.pump_mask, exp.watering, exp.write_rejected,
                       got.pump_mask, got.watering, got.write_rejected));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  sic_pkg::in_item_t           in_item;
  logic                        out_valid;
  sic_pkg::out_item_t          out_item;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sic_pkg::PADDR_W-1:0] paddr;
  logic [sic_pkg::PDATA_W-1:0] pwdata;
  logic [sic_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  irrigation_scoreboard sb;
  int                   quiet_cycles = 0;
  int                   sched_hour = 0;

  scheduled_irrigation_controller_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result check and watchdog on quiet cycles
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic sic_pkg::in_item_t mk(sic_pkg::cmd_t cmd, int hr, int day, int sample,
                                           int temp, bit tok, bit en, int mask, int mins,
                                           int area);
    sic_pkg::in_item_t it;
    it.command        = cmd;
    it.hour           = sic_pkg::HOUR_W'(hr);
    it.weekday        = sic_pkg::DAY_W'(day);
    it.soil_sample    = sic_pkg::SAMPLE_W'(sample);
    it.temperature    = sic_pkg::TEMP_W'(temp);
    it.temperature_ok = tok;
    it.slot_enable    = en;
    it.day_mask       = sic_pkg::MASK_W'(mask);
    it.minutes        = sic_pkg::MIN_W'(mins);
    it.area           = sic_pkg::AREA_W'(area);
    return it;
  endfunction

  // Mostly well-formed traffic: ticks on a slowly advancing hour, slot writes, short runs
  function automatic sic_pkg::in_item_t next_item();
    sic_pkg::in_item_t it;
    logic [63:0]       noise;
    int                pick;
    int                r;
    noise = {$urandom, $urandom};
    it    = noise[$bits(sic_pkg::in_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    if (pick < 62) begin
      it.command = sic_pkg::CMD_TICK;
      r = $urandom_range(0, 99);
      if (r < 15) sched_hour = (sched_hour + 1) % sic_pkg::SLOTS;
      it.hour = (r >= 15 && r < 20) ? sic_pkg::HOUR_W'($urandom_range(0, 31))
                                    : sic_pkg::HOUR_W'(sched_hour);
      if ($urandom_range(0, 9) != 0)
        it.weekday = sic_pkg::DAY_W'($urandom_range(1, sic_pkg::DAYS));
      if ($urandom_range(0, 3) != 0)
        it.soil_sample = sic_pkg::SAMPLE_W'($urandom_range(600, 1023));
      if ($urandom_range(0, 9) < 7) it.temperature = sic_pkg::TEMP_W'($urandom_range(0, 45));
      it.temperature_ok = ($urandom_range(0, 99) < 85);
    end else if (pick < 77) begin
      it.command     = sic_pkg::CMD_WRITE_DAYS;
      it.hour        = ($urandom_range(0, 9) != 0)
                     ? sic_pkg::HOUR_W'($urandom_range(0, sic_pkg::SLOTS - 1))
                     : sic_pkg::HOUR_W'($urandom_range(sic_pkg::SLOTS, 31));
      it.slot_enable = ($urandom_range(0, 99) < 85);
    end else if (pick < 90) begin
      it.command = sic_pkg::CMD_WRITE_MINUTES;
      it.hour    = ($urandom_range(0, 9) != 0)
                 ? sic_pkg::HOUR_W'($urandom_range(0, sic_pkg::SLOTS - 1))
                 : sic_pkg::HOUR_W'($urandom_range(sic_pkg::SLOTS, 31));
      if ($urandom_range(0, 9) != 0) it.minutes = sic_pkg::MIN_W'($urandom_range(0, 3));
    end else begin
      it.command = sic_pkg::CMD_QUICK;
      if ($urandom_range(0, 99) < 85) it.minutes = sic_pkg::MIN_W'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Present one item, with a random gap first, and hold it until accepted
  task automatic send_item(sic_pkg::in_item_t it, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    sb.note_command(it);
  endtask

  task automatic cfg_access(input bit wr, input sic_pkg::reg_idx_t idx,
                            input logic [sic_pkg::PDATA_W-1:0] wdata,
                            output logic [sic_pkg::PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = sic_pkg::PADDR_W'(idx) << 2;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) sb.set_reg(idx, wdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_reg(sic_pkg::reg_idx_t idx, logic [sic_pkg::PDATA_W-1:0] expv);
    logic [sic_pkg::PDATA_W-1:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== expv)
      sb.flag($sformatf("register %s readback: expected %0d got %0d", idx.name(), expv, rd));
  endtask

  task automatic program_regs(logic [sic_pkg::THR_W-1:0] thr, logic [sic_pkg::TEMP_W-1:0] lim,
                              logic [sic_pkg::TPM_W-1:0] tpm);
    logic [sic_pkg::PDATA_W-1:0] unused;
    cfg_access(1'b1, sic_pkg::REG_MOIST_THR, sic_pkg::PDATA_W'(thr), unused);
    cfg_access(1'b1, sic_pkg::REG_TEMP_LIM, sic_pkg::PDATA_W'(lim), unused);
    cfg_access(1'b1, sic_pkg::REG_TPM, sic_pkg::PDATA_W'(tpm), unused);
    read_reg(sic_pkg::REG_MOIST_THR, sic_pkg::PDATA_W'(thr));
    read_reg(sic_pkg::REG_TEMP_LIM, sic_pkg::PDATA_W'(lim));
    read_reg(sic_pkg::REG_TPM, sic_pkg::PDATA_W'(tpm));
  endtask

  // Stop sending and let every outstanding status come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int thr_set  [4] = '{100, 0, 127, 60};
    int lim_set  [4] = '{255, 0, 200, 40};
    int tpm_set  [4] = '{1, 63, 0, 2};
    int idle_set [4] = '{0, 53, 0, 37};
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of the registers
    read_reg(sic_pkg::REG_MOIST_THR, sic_pkg::PDATA_W'(sic_pkg::MOIST_THR_RESET));
    read_reg(sic_pkg::REG_TEMP_LIM, sic_pkg::PDATA_W'(sic_pkg::TEMP_LIM_RESET));
    read_reg(sic_pkg::REG_TPM, sic_pkg::PDATA_W'(sic_pkg::TPM_RESET));

    // directed: slot writes, rejected writes, a full scheduled run, corner ticks
    send_item(mk(sic_pkg::CMD_WRITE_DAYS, 5, 0, 0, 0, 0, 1, 127, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_WRITE_DAYS, 24, 7, 1023, 255, 1, 1, 127, 127, 15), 0);
    send_item(mk(sic_pkg::CMD_WRITE_MINUTES, 31, 0, 0, 0, 0, 0, 0, 127, 0), 0);
    send_item(mk(sic_pkg::CMD_WRITE_MINUTES, 5, 0, 0, 0, 0, 0, 0, 1, 0), 0);
    send_item(mk(sic_pkg::CMD_TICK, 5, 3, 1023, 0, 1, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_QUICK, 0, 0, 0, 0, 0, 0, 0, 50, 3), 0);
    repeat (6) send_item(mk(sic_pkg::CMD_TICK, 5, 3, 1023, 0, 1, 0, 0, 0, 0), 0);
    // slot finished: same hour not due, then a new hour clears the mark
    send_item(mk(sic_pkg::CMD_TICK, 5, 3, 1023, 255, 0, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_TICK, 6, 1, 1023, 0, 1, 0, 0, 0, 0), 0);
    // wet soil, weekday zero, hour beyond the schedule
    send_item(mk(sic_pkg::CMD_TICK, 5, 7, 0, 0, 1, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_TICK, 5, 0, 1023, 0, 1, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_TICK, 31, 2, 1023, 0, 1, 0, 0, 0, 0), 0);
    // disable keeps the days, then days cleared
    send_item(mk(sic_pkg::CMD_WRITE_DAYS, 5, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_WRITE_DAYS, 5, 0, 0, 0, 0, 1, 0, 0, 0), 0);
    // quick water with no pump, target rewritten to zero mid-run
    send_item(mk(sic_pkg::CMD_QUICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_WRITE_MINUTES, 7, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(mk(sic_pkg::CMD_QUICK, 0, 0, 0, 0, 0, 0, 0, 1, 8), 0);

    // random phases under different register settings and sender gaps
    for (int p = 0; p < 4; p++) begin
      drain();
      program_regs(sic_pkg::THR_W'(thr_set[p]), sic_pkg::TEMP_W'(lim_set[p]),
                   sic_pkg::TPM_W'(tpm_set[p]));
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(next_item(), idle_set[p]);
    end
    drain();

    if (sb.due_status.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.due_status.size()));
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
